// ===== rtl/core/rors_pkg.sv =====
`default_nettype none

package rors_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned WordW = 64;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_XLATE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_SCAN,
    S_LD_SHIFT,
    S_LD_PUT,
    S_TR_WALK,
    S_RESP
  } state_e;

  // window as held in the table: start, inclusive stop and target offset
  typedef struct packed {
    logic [WordW-1:0] src;
    logic [WordW-1:0] stop;
    logic [WordW-1:0] delta;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/rors_table.sv =====
`default_nettype none

module rors_table #(
  parameter int unsigned DEPTH = rors_pkg::TableDepthDefault,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire rors_pkg::entry_t    wdata_i,
  input  wire logic [AW-1:0]       raddr_i,
  output rors_pkg::entry_t         rdata_o
);

  rors_pkg::entry_t mem_q [DEPTH];
  rors_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/range_offset_remap_splitter.sv =====
// clear empties the table by zeroing the entry count; load scans the table entries in order,
// overwrites the entry with an equal start, otherwise is rejected with status set when the
// table is full, or else shifts the later entries up one place and inserts; translate walks
// the windows in order and emits gap and mapped pieces up to the final beat, waiting on stalls
// one item is taken at a time, the next in the cycle after the final beat is produced
// reset clears the state machine, entry count and output valid; table contents are kept
`default_nettype none

module range_offset_remap_splitter #(
  parameter int unsigned TABLE_DEPTH = rors_pkg::TableDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [63:0] window_source_i,
  input  wire logic [63:0] window_target_i,
  input  wire logic [63:0] window_length_i,
  input  wire logic [63:0] range_first_i,
  input  wire logic [63:0] range_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      piece_first_o,
  output logic [63:0]      piece_last_o,
  output logic             was_mapped_o,
  output logic             final_piece_o,
  output logic             status_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  rors_pkg::state_e state_q, state_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [63:0]      first_q, first_d;
  logic [63:0]      last_q, last_d;
  rors_pkg::entry_t ld_q, ld_d;
  logic             resp_st_q, resp_st_d;

  logic             out_valid_q, out_valid_d;
  logic [63:0]      piece_first_q, piece_last_q;
  logic             was_mapped_q, final_piece_q, status_q;

  logic             emit;
  logic [63:0]      emit_first, emit_last;
  logic             emit_mapped, emit_final, emit_status;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  rors_pkg::entry_t mem_wdata, mem_rdata;

  logic             in_accept, out_free, at_end, full;
  logic             last_lt_src, first_lt_src, last_le_stop, first_le_stop;
  logic             src_eq, src_gt, walk_done;
  logic [63:0]      first_map, last_map, stop_map, src_m1, stop_p1;

  rors_table #(
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o = (state_q == rors_pkg::S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign at_end     = (idx_q == count_q);
  assign full       = (count_q == CW'(TABLE_DEPTH));

  // read data belongs to idx_q while idx_q is below the table depth, as the read goes out at idx_d
  assign mem_raddr  = (idx_d < CW'(TABLE_DEPTH)) ? idx_d[AW-1:0] : '0;

  assign last_lt_src   = last_q < mem_rdata.src;
  assign first_lt_src  = first_q < mem_rdata.src;
  assign last_le_stop  = last_q <= mem_rdata.stop;
  assign first_le_stop = first_q <= mem_rdata.stop;
  assign src_eq        = mem_rdata.src == ld_q.src;
  assign src_gt        = mem_rdata.src > ld_q.src;
  assign walk_done     = at_end || last_lt_src || (!first_lt_src && last_le_stop);

  assign first_map = first_q + mem_rdata.delta;
  assign last_map  = last_q + mem_rdata.delta;
  assign stop_map  = mem_rdata.stop + mem_rdata.delta;
  assign src_m1    = mem_rdata.src - 64'd1;
  assign stop_p1   = mem_rdata.stop + 64'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rors_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            rors_pkg::ACT_LOAD:  state_d = rors_pkg::S_LD_SCAN;
            rors_pkg::ACT_CLEAR: state_d = rors_pkg::S_RESP;
            rors_pkg::ACT_XLATE: state_d = rors_pkg::S_TR_WALK;
            default:             state_d = rors_pkg::S_IDLE;
          endcase
        end
      end
      rors_pkg::S_LD_SCAN: begin
        if (!at_end && src_eq) begin
          state_d = rors_pkg::S_RESP;
        end else if (at_end || src_gt) begin
          if (full) begin
            state_d = rors_pkg::S_RESP;
          end else if (at_end) begin
            state_d = rors_pkg::S_LD_PUT;
          end else begin
            state_d = rors_pkg::S_LD_SHIFT;
          end
        end
      end
      rors_pkg::S_LD_SHIFT: begin
        if (idx_q[AW-1:0] == pos_q) begin
          state_d = rors_pkg::S_LD_PUT;
        end
      end
      rors_pkg::S_LD_PUT: state_d = rors_pkg::S_RESP;
      rors_pkg::S_TR_WALK: begin
        if (walk_done && out_free) begin
          state_d = rors_pkg::S_IDLE;
        end
      end
      rors_pkg::S_RESP: begin
        if (out_free) begin
          state_d = rors_pkg::S_IDLE;
        end
      end
      default: state_d = rors_pkg::S_IDLE;
    endcase
  end

  // datapath, table port and beat generation
  always_comb begin
    idx_d       = idx_q;
    pos_d       = pos_q;
    count_d     = count_q;
    first_d     = first_q;
    last_d      = last_q;
    ld_d        = ld_q;
    resp_st_d   = resp_st_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = ld_q;
    emit        = 1'b0;
    emit_first  = '0;
    emit_last   = '0;
    emit_mapped = 1'b0;
    emit_final  = 1'b0;
    emit_status = 1'b0;
    case (state_q)
      rors_pkg::S_IDLE: begin
        idx_d = '0;
        if (in_valid_i) begin
          first_d    = range_first_i;
          last_d     = range_last_i;
          ld_d.src   = window_source_i;
          ld_d.stop  = window_source_i + window_length_i - 64'd1;
          ld_d.delta = window_target_i - window_source_i;
          resp_st_d  = 1'b0;
          if (action_i == rors_pkg::ACT_CLEAR) begin
            count_d = '0;
          end
        end
      end
      rors_pkg::S_LD_SCAN: begin
        if (!at_end && src_eq) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q[AW-1:0];
        end else if (at_end || src_gt) begin
          pos_d = idx_q[AW-1:0];
          if (full) begin
            resp_st_d = 1'b1;
          end else if (!at_end) begin
            idx_d = count_q - CW'(1);
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      rors_pkg::S_LD_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0] + AW'(1);
        mem_wdata = mem_rdata;
        if (idx_q[AW-1:0] != pos_q) begin
          idx_d = idx_q - CW'(1);
        end
      end
      rors_pkg::S_LD_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        count_d   = count_q + CW'(1);
      end
      rors_pkg::S_TR_WALK: begin
        if (at_end || last_lt_src) begin
          emit       = out_free;
          emit_first = first_q;
          emit_last  = last_q;
          emit_final = 1'b1;
        end else if (first_lt_src) begin
          emit       = out_free;
          emit_first = first_q;
          emit_last  = src_m1;
          if (out_free) begin
            first_d = mem_rdata.src;
          end
        end else if (last_le_stop) begin
          emit        = out_free;
          emit_first  = first_map;
          emit_last   = last_map;
          emit_mapped = 1'b1;
          emit_final  = 1'b1;
        end else if (first_le_stop) begin
          emit        = out_free;
          emit_first  = first_map;
          emit_last   = stop_map;
          emit_mapped = 1'b1;
          if (out_free) begin
            first_d = stop_p1;
            idx_d   = idx_q + CW'(1);
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      rors_pkg::S_RESP: begin
        emit        = out_free;
        emit_final  = 1'b1;
        emit_status = resp_st_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rors_pkg::S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    first_q   <= first_d;
    last_q    <= last_d;
    ld_q      <= ld_d;
    resp_st_q <= resp_st_d;
    if (emit) begin
      piece_first_q <= emit_first;
      piece_last_q  <= emit_last;
      was_mapped_q  <= emit_mapped;
      final_piece_q <= emit_final;
      status_q      <= emit_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign piece_first_o = piece_first_q;
  assign piece_last_o  = piece_last_q;
  assign was_mapped_o  = was_mapped_q;
  assign final_piece_o = final_piece_q;
  assign status_o      = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_shift_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rors_pkg::S_LD_SHIFT |-> idx_q < count_q && !full)
    else $error("shift source outside filled entries");

  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_final |=> state_q == rors_pkg::S_IDLE)
    else $error("final beat without return to idle");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && action_i == rors_pkg::ACT_CLEAR |=> count_q == '0)
    else $error("clear left entries in table");

endmodule

`default_nettype wire
